// ===== design/jsu_pkg.sv =====
package jsu_pkg;

	// most bytes one input item can cause
	localparam int MaxBytes = 4;

	// result bytes of one item, slot 0 goes out first
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [1:0]               last;   // index of the final valid slot
	} job_t;

endpackage

// ===== design/json_string_unescape_utf8.sv =====
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_byte[7:0], end_of_string
// out       out  out_valid / out_stall  out_byte[7:0], run_last
//
// input takes one byte a cycle; each item yields zero to four output bytes
// output gives one byte a cycle, so a long run of multi-byte results is bounded by the out side
// a queue of 2**QUEUE_DEPTH_LOG2 result groups sits between the decoder and the byte serializer
// in_stall rises only while that queue is full; out_stall holds the current byte
// arst_n clears the decoder to plain mode and empties the queue
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH_LOG2 = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic          accept;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	jsu_pkg::job_t push_job;
	jsu_pkg::job_t pop_job;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	jsu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.push          (push),
		.push_job      (push_job)
	);

	jsu_queue #(
		.DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (full),
		.empty    (empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

// ===== design/jsu_front.sv =====
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          end_of_string,
	output logic          push,
	output jsu_pkg::job_t push_job
);

	localparam logic [2:0] MODE_PLAIN   = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_HEX1    = 3'd2;
	localparam logic [2:0] MODE_HIGH    = 3'd3;
	localparam logic [2:0] MODE_HIGH_BS = 3'd4;
	localparam logic [2:0] MODE_HEX2    = 3'd5;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_A_UP   = 8'h41;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] accum_q, accum_d;
	logic [15:0] high_q, high_d;

	logic [3:0]  nib;
	logic [15:0] acc_next;
	logic [20:0] pair_cp;
	logic [3:0][7:0] ob;
	logic [2:0]  n;
	logic [2:0]  n_m1;

	// letters at or above 'A' are folded to upper case and shifted down by seven
	assign nib      = (in_byte >= CH_A_UP) ? (in_byte[3:0] - 4'd7) : in_byte[3:0];
	assign acc_next = {accum_q[11:0], nib};
	assign pair_cp  = {({1'b0, high_q[9:6]} + 5'd1), high_q[5:0], acc_next[9:0]};

	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		accum_d   = accum_q;
		high_d    = high_q;
		ob        = '0;
		n         = 3'd0;

		case (mode_q)
			MODE_ESC, MODE_HIGH_BS: begin
				if (mode_q == MODE_HIGH_BS && in_byte == CH_U) begin
					mode_d    = MODE_HEX2;
					hex_cnt_d = 2'd0;
					accum_d   = '0;
				end else begin
					if (mode_q == MODE_HIGH_BS) begin
						ob[n[1:0]] = CH_QMARK;
						n = n + 3'd1;
					end
					mode_d = MODE_PLAIN;
					case (in_byte)
						CH_N: begin ob[n[1:0]] = 8'h0A; n = n + 3'd1; end
						CH_T: begin ob[n[1:0]] = 8'h09; n = n + 3'd1; end
						CH_R: begin ob[n[1:0]] = 8'h0D; n = n + 3'd1; end
						CH_B: begin ob[n[1:0]] = 8'h08; n = n + 3'd1; end
						CH_F: begin ob[n[1:0]] = 8'h0C; n = n + 3'd1; end
						CH_BSLASH, CH_QUOTE, CH_SLASH: begin
							ob[n[1:0]] = in_byte;
							n = n + 3'd1;
						end
						CH_U: begin
							mode_d    = MODE_HEX1;
							hex_cnt_d = 2'd0;
							accum_d   = '0;
						end
						default: begin
							// unknown escape drops out silently
						end
					endcase
				end
			end
			MODE_HEX1: begin
				accum_d = acc_next;
				if (hex_cnt_q == 2'd3) begin
					hex_cnt_d = 2'd0;
					if (acc_next[15:10] == 6'b110110) begin
						high_d = acc_next;
						mode_d = MODE_HIGH;
					end else begin
						mode_d = MODE_PLAIN;
						if (acc_next < 16'h0080) begin
							ob[0] = acc_next[7:0];
							n = 3'd1;
						end else if (acc_next < 16'h0800) begin
							ob[0] = {3'b110, acc_next[10:6]};
							ob[1] = {2'b10, acc_next[5:0]};
							n = 3'd2;
						end else begin
							ob[0] = {4'b1110, acc_next[15:12]};
							ob[1] = {2'b10, acc_next[11:6]};
							ob[2] = {2'b10, acc_next[5:0]};
							n = 3'd3;
						end
					end
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end
			MODE_HIGH: begin
				if (in_byte == CH_BSLASH) begin
					mode_d = MODE_HIGH_BS;
				end else begin
					// unpaired high half, then the byte passes as plain
					ob[0] = CH_QMARK;
					ob[1] = in_byte;
					n = 3'd2;
					mode_d = MODE_PLAIN;
				end
			end
			MODE_HEX2: begin
				accum_d = acc_next;
				if (hex_cnt_q == 2'd3) begin
					hex_cnt_d = 2'd0;
					mode_d = MODE_PLAIN;
					ob[0] = {5'b11110, pair_cp[20:18]};
					ob[1] = {2'b10, pair_cp[17:12]};
					ob[2] = {2'b10, pair_cp[11:6]};
					ob[3] = {2'b10, pair_cp[5:0]};
					n = 3'd4;
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end
			default: begin
				if (in_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d = MODE_PLAIN;
					ob[0] = in_byte;
					n = 3'd1;
				end
			end
		endcase

		if (end_of_string) begin
			if (mode_d == MODE_HIGH || mode_d == MODE_HIGH_BS || mode_d == MODE_HEX2) begin
				ob[n[1:0]] = CH_QMARK;
				n = n + 3'd1;
			end
			mode_d    = MODE_PLAIN;
			hex_cnt_d = 2'd0;
			accum_d   = '0;
			high_d    = '0;
		end

		n_m1 = n - 3'd1;
	end

	assign push           = accept && (n != 3'd0);
	assign push_job.bytes = ob;
	assign push_job.last  = n_m1[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			hex_cnt_q <= 2'd0;
			accum_q   <= '0;
			high_q    <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			accum_q   <= accum_d;
			high_q    <= high_d;
		end
	end

	// string end always leaves the decoder fresh
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_string |=> mode_q == MODE_PLAIN && hex_cnt_q == 2'd0)
		else $error("decoder state not cleared after string end");

	// digit count only moves inside a hex run
	assert property (@(posedge clk) disable iff (!arst_n)
		hex_cnt_q != 2'd0 |-> mode_q == MODE_HEX1 || mode_q == MODE_HEX2)
		else $error("hex digit count outside hex mode");

	// four bytes only come from a completed surrogate pair
	assert property (@(posedge clk) disable iff (!arst_n)
		push && push_job.last == 2'd3 |-> mode_q == MODE_HEX2 && hex_cnt_q == 2'd3)
		else $error("four byte burst outside surrogate pair");

endmodule

// ===== design/jsu_queue.sv =====
module jsu_queue #(
	parameter int DEPTH_LOG2 = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::job_t push_job,
	input  logic          pop,
	output jsu_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);

	localparam int Depth = 1 << DEPTH_LOG2;

	jsu_pkg::job_t         mem_q [Depth];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;

	assign full    = count_q == (DEPTH_LOG2 + 1)'(Depth);
	assign empty   = count_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("write into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("read from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (DEPTH_LOG2 + 1)'(Depth))
		else $error("queue count beyond depth");

endmodule

// ===== design/jsu_back.sv =====
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  jsu_pkg::job_t pop_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          run_last
);

	logic [jsu_pkg::MaxBytes-1:0][7:0] bytes_q;
	logic [1:0] rem_q;
	logic       valid_q;
	logic       take;

	assign take = valid_q && !out_stall;
	// next item loads as the last byte of the current one leaves
	assign pop  = !empty && (!valid_q || (take && rem_q == 2'd0));

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= pop_job.bytes;
		end else if (take) begin
			bytes_q <= {8'h00, bytes_q[jsu_pkg::MaxBytes-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			rem_q   <= pop_job.last;
		end else if (take) begin
			if (rem_q != 2'd0) begin
				rem_q <= rem_q - 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = bytes_q[0];
	assign run_last  = rem_q == 2'd0;

	assert property (@(posedge clk) disable iff (!arst_n) !valid_q |-> rem_q == 2'd0)
		else $error("bytes left with no item held");

	assert property (@(posedge clk) disable iff (!arst_n)
		take && rem_q != 2'd0 |=> valid_q && rem_q == $past(rem_q) - 2'd1)
		else $error("burst count did not step down");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q && rem_q == $past(rem_q))
		else $error("stalled burst changed");

endmodule

// ===== bench/tb_json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

	typedef enum logic [2:0] {
		DM_PLAIN,
		DM_ESC,
		DM_HEX1,
		DM_HIGH,
		DM_HIGH_BS,
		DM_HEX2
	} decode_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} raw_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} ubyte_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_FF  = 8'h0C;

	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 60;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 12;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	json_string_unescape_utf8 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	raw_t   raw_bytes[$];
	ubyte_t want_bytes[$];
	logic [7:0] tok_buf[$];
	logic [7:0] burst[$];

	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_go = 1'b0;
	logic hold_active = 1'b0;
	int  mismatches = 0;
	raw_t   next_raw;
	ubyte_t got_want;

	// unescaper state
	decode_mode_t dmode = DM_PLAIN;
	logic [1:0]   hex_cnt = 2'd0;
	logic [15:0]  code_acc = 16'h0000;
	logic [15:0]  high_half = 16'h0000;

	function automatic void put_utf8(input logic [31:0] cp);
		if (cp < 32'h80) begin
			burst.push_back(cp[7:0]);
		end else if (cp < 32'h800) begin
			burst.push_back(8'hC0 | {3'b000, cp[10:6]});
			burst.push_back(8'h80 | {2'b00, cp[5:0]});
		end else if (cp < 32'h10000) begin
			burst.push_back(8'hE0 | {4'h0, cp[15:12]});
			burst.push_back(8'h80 | {2'b00, cp[11:6]});
			burst.push_back(8'h80 | {2'b00, cp[5:0]});
		end else if (cp < 32'h200000) begin
			burst.push_back(8'hF0 | {5'b00000, cp[20:18]});
			burst.push_back(8'h80 | {2'b00, cp[17:12]});
			burst.push_back(8'h80 | {2'b00, cp[11:6]});
			burst.push_back(8'h80 | {2'b00, cp[5:0]});
		end else begin
			burst.push_back(CH_QMARK);
		end
	endfunction

	// any byte yields a nibble, hex or not
	function automatic bit take_hex(input logic [7:0] b);
		logic [7:0] c;
		c = b;
		if (c >= CH_UPPER_A)
			c = (c & 8'hDF) - 8'd7;
		c = c - CH_ZERO;
		code_acc = {code_acc[11:0], c[3:0]};
		if (hex_cnt == 2'd3) begin
			hex_cnt = 2'd0;
			return 1'b1;
		end
		hex_cnt = hex_cnt + 2'd1;
		return 1'b0;
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (b == CH_BSLASH)
			dmode = DM_ESC;
		else
			burst.push_back(b);
	endfunction

	function automatic void take_escape(input logic [7:0] b);
		dmode = DM_PLAIN;
		case (b)
			CH_N: burst.push_back(CODE_LF);
			CH_T: burst.push_back(CODE_TAB);
			CH_R: burst.push_back(CODE_CR);
			CH_B: burst.push_back(CODE_BS);
			CH_F: burst.push_back(CODE_FF);
			CH_BSLASH, CH_DQUOTE, CH_SLASH: burst.push_back(b);
			CH_U: begin
				dmode = DM_HEX1;
				hex_cnt = 2'd0;
				code_acc = 16'h0000;
			end
			default: ;
		endcase
	endfunction

	function automatic void unescape_item(input logic [7:0] b, input logic eos);
		logic [31:0] sup;
		int          n;
		burst = {};
		case (dmode)
			DM_ESC: take_escape(b);
			DM_HEX1: begin
				if (take_hex(b)) begin
					if ((code_acc & 16'hFC00) == 16'hD800) begin
						high_half = code_acc;
						dmode = DM_HIGH;
					end else begin
						put_utf8({16'h0000, code_acc});
						dmode = DM_PLAIN;
					end
				end
			end
			DM_HIGH: begin
				if (b == CH_BSLASH) begin
					dmode = DM_HIGH_BS;
				end else begin
					burst.push_back(CH_QMARK);
					dmode = DM_PLAIN;
					take_plain(b);
				end
			end
			DM_HIGH_BS: begin
				if (b == CH_U) begin
					dmode = DM_HEX2;
					hex_cnt = 2'd0;
					code_acc = 16'h0000;
				end else begin
					burst.push_back(CH_QMARK);
					take_escape(b);
				end
			end
			DM_HEX2: begin
				if (take_hex(b)) begin
					sup = ((32'(high_half) & 32'h3F) << 10)
						| ((((32'(high_half) >> 6) & 32'hF) + 32'd1) << 16)
						| (32'(code_acc) & 32'h3FF);
					put_utf8(sup);
					dmode = DM_PLAIN;
				end
			end
			default: begin
				dmode = DM_PLAIN;
				take_plain(b);
			end
		endcase
		if (eos) begin
			// a dangling high surrogate still turns into a question mark
			if (dmode == DM_HIGH || dmode == DM_HIGH_BS || dmode == DM_HEX2)
				burst.push_back(CH_QMARK);
			dmode = DM_PLAIN;
			hex_cnt = 2'd0;
			code_acc = 16'h0000;
			high_half = 16'h0000;
		end
		n = (burst.size() > 4) ? 4 : burst.size();
		for (int k = 0; k < n; k++)
			want_bytes.push_back('{data: burst[k], is_last: (k == n - 1)});
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			end_of_string <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (raw_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				next_raw = raw_bytes.pop_front();
				in_valid <= 1'b1;
				in_byte <= next_raw.data;
				end_of_string <= next_raw.eos;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver side stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
	end

	// long hold-off so the result queue fills and the input stalls
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// monitor: predict on accepted input, then check accepted output
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				unescape_item(in_byte, end_of_string);
			if (out_valid && !out_stall) begin
				if (want_bytes.size() == 0) begin
					$display("%0t: out_byte %02h run_last %0b arrived with none expected",
						$time, out_byte, run_last);
					mismatches++;
				end else begin
					got_want = want_bytes.pop_front();
					if (out_byte !== got_want.data) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, got_want.data, out_byte);
						mismatches++;
					end
					if (run_last !== got_want.is_last) begin
						$display("%0t: run_last expected %0b actual %0b",
							$time, got_want.is_last, run_last);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			tok_buf.push_back(s[i]);
	endtask

	task automatic flush_token(input bit eos);
		int i;
		for (i = 0; i < tok_buf.size(); i++)
			raw_bytes.push_back('{data: tok_buf[i], eos: eos && (i == tok_buf.size() - 1)});
		tok_buf = {};
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return CH_ZERO + {4'h0, nib};
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + {4'h0, nib} - 8'd10;
	endfunction

	task automatic push_u(input logic [15:0] cp);
		int i;
		tok_buf.push_back(CH_BSLASH);
		tok_buf.push_back(CH_U);
		for (i = 3; i >= 0; i--)
			tok_buf.push_back(hex_char(cp[i*4 +: 4]));
	endtask

	function automatic logic [7:0] escape_char();
		case ($urandom_range(0, 7))
			0: return CH_N;
			1: return CH_T;
			2: return CH_R;
			3: return CH_B;
			4: return CH_F;
			5: return CH_BSLASH;
			6: return CH_DQUOTE;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 16'h7F));
			1: return 16'($urandom_range(16'h80, 16'h7FF));
			2: return 16'h0000;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic add_random_token();
		int cut;
		bit eos;
		case ($urandom_range(0, 11))
			0, 1, 2: tok_buf.push_back(8'($urandom_range(0, 255)));
			3, 4: begin
				tok_buf.push_back(CH_BSLASH);
				tok_buf.push_back(escape_char());
			end
			5, 6: push_u(pick_code());
			7, 8: begin
				push_u(16'hD800 | 16'($urandom_range(0, 1023)));
				if ($urandom_range(0, 3) == 0)
					push_u(16'($urandom_range(0, 16'hFFFF)));
				else
					push_u(16'hDC00 | 16'($urandom_range(0, 1023)));
			end
			9: begin
				// high surrogate left alone, then a random byte or a backslash and an escape or random byte
				push_u(16'hD800 | 16'($urandom_range(0, 1023)));
				if ($urandom_range(0, 1)) begin
					tok_buf.push_back(CH_BSLASH);
					tok_buf.push_back($urandom_range(0, 1) ? escape_char()
						: 8'($urandom_range(0, 255)));
				end else begin
					tok_buf.push_back(8'($urandom_range(0, 255)));
				end
			end
			10: begin
				tok_buf.push_back(CH_BSLASH);
				tok_buf.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				// digits that are mostly not hex
				tok_buf.push_back(CH_BSLASH);
				tok_buf.push_back(CH_U);
				repeat (4) tok_buf.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if (tok_buf.size() > 1 && $urandom_range(0, 14) == 0) begin
			cut = $urandom_range(1, tok_buf.size() - 1);
			while (tok_buf.size() > cut)
				void'(tok_buf.pop_back());
			eos = 1'b1;
		end else begin
			eos = ($urandom_range(0, 9) == 0);
		end
		flush_token(eos);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((raw_bytes.size() != 0 || in_valid || want_bytes.size() != 0)
				&& guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 61, 0, 7};
		stall_set = '{0, 0, 61, 7};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tok_buf.push_back(8'h00);
		tok_buf.push_back(8'hFF);
		flush_token(1'b0);
		push_text("\\n\\\"");
		flush_token(1'b0);
		push_text("\\q");
		flush_token(1'b0);
		push_text("\\u20AC");
		flush_token(1'b0);
		push_text("\\uD83D\\uDE00");
		flush_token(1'b0);
		push_text("\\uD800x");
		flush_token(1'b0);
		push_text("\\uDBFF\\t");
		flush_token(1'b0);
		push_text("\\u0000");
		flush_token(1'b0);
		push_text("\\uzZ");
		flush_token(1'b1);
		push_text("\\uD800");
		flush_token(1'b1);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			@(negedge clk);
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			if (p == 0)
				hold_go = 1'b1;
			while (raw_bytes.size() < PHASE_ITEMS)
				add_random_token();
			// sender pauses here until every result is back
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (want_bytes.size() != 0) begin
			$display("%0t: %0d expected bytes never arrived", $time, want_bytes.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb_json_string_unescape_utf8 passed");
		end else begin
			$display("tb_json_string_unescape_utf8 failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_json_string_unescape_utf8 failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
bench/tb_json_string_unescape_utf8.sv
